[rtl/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 50;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int IDX_W = $clog2(CELL_COUNT);

   // Field widths on the ports
   localparam int CHAR_W     = 8;
   localparam int CELL_IDX_W = 12;
   localparam int OUT_COL_W  = 7;
   localparam int OUT_ROW_W  = 6;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Control characters
   localparam logic [CHAR_W-1:0] CH_CLEAR   = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h1F;
   localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

   // Sweep bounds and cursor constants
   localparam logic [IDX_W-1:0] LAST_CELL     = IDX_W'(CELL_COUNT - 1);
   localparam logic [IDX_W-1:0] MOVE_LAST     = IDX_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [IDX_W-1:0] BLANK_FIRST   = IDX_W'(CELL_COUNT - COLUMNS);
   localparam logic [IDX_W-1:0] LAST_ROW_BASE = IDX_W'((ROWS - 1) * COLUMNS);
   localparam logic [IDX_W-1:0] COLUMNS_IDX   = IDX_W'(COLUMNS);
   localparam logic [COL_W:0]   COLUMNS_COL   = (COL_W + 1)'(COLUMNS);
   localparam logic [ROW_W-1:0] LAST_ROW      = ROW_W'(ROWS - 1);

   // Item kind on the request tuser
   localparam logic KIND_PRINT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      OP_PUT     = 3'd0,
      OP_CLEAR   = 3'd1,
      OP_RETURN  = 3'd2,
      OP_NEWLINE = 3'd3,
      OP_READ    = 3'd4
   } tcw_op_type;

   typedef struct packed {
      tcw_op_type        op;
      logic [CHAR_W-1:0] character;
      logic [IDX_W-1:0]  cell_addr;
      logic              in_range;
   } tcw_cmd_type;

   typedef struct packed {
      logic             init_busy;
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
   } tcw_status_type;

endpackage

`default_nettype wire

[rtl/text_console_writer_core.sv]
// Teletype-style text console over an 80 by 50 store of 16-bit cells
// (attribute in the high byte, character in the low byte). A request with
// tuser 0 prints the byte in tdata: form feed clears the screen and homes the
// cursor, carriage return goes to column 0, line feed to the next line, any
// other byte is stored with the current attribute and the cursor advances,
// wrapping and scrolling at the edges. A request with tuser 1 reads one cell
// by linear index; an index past the store reads as zero. Every request gives
// one response with the cursor column and row after it. After reset the
// store is swept to blank (attribute 0x1F, space), during which req_tready
// stays low. Cost per item is set by the single write port of the cell
// store: a read writes no cell, a printed byte or cursor move at most one,
// a clear every cell, and a print that scrolls moves every cell below the
// top row up one row, then blanks the last row. Two requests can wait in
// the command queue while a response is held for the consumer.
`default_nettype none

module text_console_writer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [7:0] character, [19:8] cell_index, [23:20] zero
   input  wire logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [6:0] cursor_column, [12:7] cursor_row, [28:13] cell_value, [31:29] zero
   output logic [tcw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     csr_data
);

   tcw_pkg::tcw_status_type status;
   tcw_pkg::tcw_cmd_type    push_cmd;
   tcw_pkg::tcw_cmd_type    q_cmd;
   logic                    push;
   logic                    queue_full;
   logic                    q_valid;
   logic                    q_pop;

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tcw_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .status     (status)
   );

   // Cursor stays inside the screen
   assert property (@(posedge clock) disable iff (reset)
      (32'(status.cursor_col) < tcw_pkg::COLUMNS) &&
      (32'(status.cursor_row) < tcw_pkg::ROWS))
      else $error("cursor outside the screen");

   // No item is taken during the clearing pass after reset
   assert property (@(posedge clock) status.init_busy |-> !req_tready)
      else $error("request accepted during clearing pass");

   // The clearing pass never restarts once finished
   assert property (@(posedge clock) disable iff (reset)
      !status.init_busy |=> !status.init_busy)
      else $error("clearing pass restarted");

   // A command is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) queue_full |-> !push)
      else $error("push into full command queue");

endmodule

`default_nettype wire

[rtl/tcw_front.sv]
`default_nettype none

module tcw_front (
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [7:0] character, [19:8] cell_index, rest zero
   input  wire logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  wire logic                           req_tuser,
   input  wire tcw_pkg::tcw_status_type        status,
   input  wire logic                           queue_full,
   output logic                                push,
   output tcw_pkg::tcw_cmd_type                push_cmd
);

   logic [tcw_pkg::CHAR_W-1:0]                   character;
   logic [tcw_pkg::CELL_IDX_W-1:0]               cell_index;
   logic [tcw_pkg::CELL_IDX_W+tcw_pkg::IDX_W-1:0] cell_wide;

   assign character  = req_tdata[tcw_pkg::CHAR_W-1:0];
   assign cell_index = req_tdata[tcw_pkg::CHAR_W+tcw_pkg::CELL_IDX_W-1:tcw_pkg::CHAR_W];
   assign cell_wide  = {{tcw_pkg::IDX_W{1'b0}}, cell_index};

   // Hold off items while the store is being cleared or the queue is full
   assign req_tready = !status.init_busy && !queue_full;
   assign push       = req_tvalid && req_tready;

   // Classify the item into a command for the back end
   always_comb begin
      push_cmd.character = character;
      push_cmd.cell_addr = cell_wide[tcw_pkg::IDX_W-1:0];
      push_cmd.in_range  = (32'(cell_index) < tcw_pkg::CELL_COUNT);
      if (req_tuser == tcw_pkg::KIND_READ) begin
         push_cmd.op = tcw_pkg::OP_READ;
      end else if (character == tcw_pkg::CH_CLEAR) begin
         push_cmd.op = tcw_pkg::OP_CLEAR;
      end else if (character == tcw_pkg::CH_RETURN) begin
         push_cmd.op = tcw_pkg::OP_RETURN;
      end else if (character == tcw_pkg::CH_NEWLINE) begin
         push_cmd.op = tcw_pkg::OP_NEWLINE;
      end else begin
         push_cmd.op = tcw_pkg::OP_PUT;
      end
   end

endmodule

`default_nettype wire

[rtl/tcw_cmd_queue.sv]
`default_nettype none

module tcw_cmd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tcw_pkg::tcw_cmd_type push_cmd,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output tcw_pkg::tcw_cmd_type      pop_cmd
);

   tcw_pkg::tcw_cmd_type             entry_ff [tcw_pkg::QUEUE_DEPTH];
   logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QPTR_W:0]         count_ff, count_in;

   assign full      = (count_ff == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && pop_valid) begin
         rd_ptr_in = (rd_ptr_ff == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !(pop && pop_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && pop_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/tcw_back.sv]
`default_nettype none

module tcw_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  wire tcw_pkg::tcw_cmd_type           q_cmd,
   output logic                                q_pop,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tcw_pkg::ATTR_W-1:0]     csr_data,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output tcw_pkg::tcw_status_type             status
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_FILL  = 7'b0001000,
      S_MOVE  = 7'b0010000,
      S_BLANK = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [tcw_pkg::IDX_W-1:0]        sweep_ff, sweep_in;
   logic                             pend_ff, pend_in;
   logic [tcw_pkg::IDX_W-1:0]        move_addr_ff, move_addr_in;
   logic [tcw_pkg::ATTR_W-1:0]       attr_ff, attr_in;
   logic [tcw_pkg::COL_W-1:0]        col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [tcw_pkg::IDX_W-1:0]        cursor_ff, cursor_in;
   logic [tcw_pkg::CELL_W-1:0]       res_value_ff, res_value_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::OUT_COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::OUT_ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [tcw_pkg::CELL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [tcw_pkg::CELL_W-1:0]       rd_data_ff;

   // Cell store
   logic [tcw_pkg::CELL_W-1:0]       cells_mem [tcw_pkg::CELL_COUNT];
   logic                             mem_we;
   logic [tcw_pkg::IDX_W-1:0]        mem_waddr;
   logic [tcw_pkg::CELL_W-1:0]       mem_wdata;
   logic [tcw_pkg::IDX_W-1:0]        mem_raddr;

   logic [tcw_pkg::CELL_W-1:0]       blank;
   logic [tcw_pkg::COL_W:0]          col_plus;
   logic                             wrap;
   logic                             scroll;
   logic [tcw_pkg::IDX_W-1:0]        line_start;
   logic [tcw_pkg::COL_W+tcw_pkg::OUT_COL_W-1:0] col_wide;
   logic [tcw_pkg::ROW_W+tcw_pkg::OUT_ROW_W-1:0] row_wide;

   assign blank      = {attr_ff, tcw_pkg::CH_SPACE};
   assign csr_ready  = 1'b1;
   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign col_plus   = {1'b0, col_ff} + 1'b1;
   assign line_start = cursor_ff - tcw_pkg::IDX_W'(col_ff);
   assign wrap       = ((q_cmd.op == tcw_pkg::OP_PUT) && (col_plus == tcw_pkg::COLUMNS_COL)) ||
                       (q_cmd.op == tcw_pkg::OP_NEWLINE);
   assign scroll     = wrap && (row_ff == tcw_pkg::LAST_ROW);

   // Mask cursor coordinates to the result field widths
   assign col_wide = {{tcw_pkg::OUT_COL_W{1'b0}}, col_ff};
   assign row_wide = {{tcw_pkg::OUT_ROW_W{1'b0}}, row_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tcw_pkg::RSP_DATA_W - tcw_pkg::CELL_W - tcw_pkg::OUT_ROW_W -
                          tcw_pkg::OUT_COL_W){1'b0}}, rsp_value_ff, rsp_row_ff, rsp_col_ff};

   assign status.init_busy  = (state_ff == S_INIT);
   assign status.cursor_col = col_ff;
   assign status.cursor_row = row_ff;

   // Sequencer: execute commands, sweep the store after reset and for clear and scroll
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      pend_in      = pend_ff;
      move_addr_in = move_addr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cursor_in    = cursor_ff;
      res_value_in = res_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_value_in = rsp_value_ff;
      mem_we       = 1'b0;
      mem_waddr    = sweep_ff;
      mem_wdata    = blank;
      mem_raddr    = q_cmd.cell_addr;
      case (state_ff)
         S_INIT, S_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = (state_ff == S_INIT) ? tcw_pkg::BLANK_RESET : blank;
            if (sweep_ff == tcw_pkg::LAST_CELL) begin
               sweep_in = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               res_value_in = '0;
               case (q_cmd.op)
                  tcw_pkg::OP_READ: begin
                     state_in = q_cmd.in_range ? S_READ : S_DONE;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in    = '0;
                     row_in    = '0;
                     cursor_in = '0;
                     sweep_in  = '0;
                     state_in  = S_FILL;
                  end
                  default: begin
                     // Write a printable byte at the cursor, then move the cursor
                     if (q_cmd.op == tcw_pkg::OP_PUT) begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_ff;
                        mem_wdata = {attr_ff, q_cmd.character};
                     end
                     if (q_cmd.op == tcw_pkg::OP_RETURN || wrap) begin
                        col_in = '0;
                     end else begin
                        col_in = col_plus[tcw_pkg::COL_W-1:0];
                     end
                     if (scroll) begin
                        cursor_in = tcw_pkg::LAST_ROW_BASE;
                        sweep_in  = '0;
                        pend_in   = 1'b0;
                        state_in  = S_MOVE;
                     end else begin
                        if (wrap) begin
                           row_in = row_ff + 1'b1;
                        end
                        if (q_cmd.op == tcw_pkg::OP_RETURN) begin
                           cursor_in = line_start;
                        end else if (q_cmd.op == tcw_pkg::OP_NEWLINE) begin
                           cursor_in = line_start + tcw_pkg::COLUMNS_IDX;
                        end else begin
                           cursor_in = cursor_ff + 1'b1;
                        end
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            res_value_in = rd_data_ff;
            state_in     = S_DONE;
         end
         S_MOVE: begin
            // Read one row ahead, write the previous read back one row up
            mem_raddr    = sweep_ff + tcw_pkg::COLUMNS_IDX;
            mem_we       = pend_ff;
            mem_waddr    = move_addr_ff;
            mem_wdata    = rd_data_ff;
            pend_in      = 1'b1;
            move_addr_in = sweep_ff;
            if (sweep_ff == tcw_pkg::MOVE_LAST) begin
               sweep_in = tcw_pkg::BLANK_FIRST;
               state_in = S_BLANK;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_BLANK: begin
            mem_we = 1'b1;
            if (pend_ff) begin
               // Finish the last moved cell first
               mem_waddr = move_addr_ff;
               mem_wdata = rd_data_ff;
               pend_in   = 1'b0;
            end else if (sweep_ff == tcw_pkg::LAST_CELL) begin
               sweep_in = '0;
               state_in = S_DONE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_DONE: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_wide[tcw_pkg::OUT_COL_W-1:0];
               rsp_row_in   = row_wide[tcw_pkg::OUT_ROW_W-1:0];
               rsp_value_in = res_value_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Take attribute writes
   always_comb begin
      attr_in = attr_ff;
      if (csr_valid && csr_ready) begin
         attr_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         attr_ff      <= attr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      move_addr_ff <= move_addr_in;
      res_value_ff <= res_value_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Store write port and registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= cells_mem[mem_raddr];
   end

endmodule

`default_nettype wire
